// File: src/uart_baud_divisor_encoder_macros.svh
// Assertion macros of the baud divisor encoder RTL, used by its queue.
// Included by files that carry concurrent checks; depends on clk and rst_n in scope.
`ifndef UART_BAUD_DIVISOR_ENCODER_MACROS_SVH
`define UART_BAUD_DIVISOR_ENCODER_MACROS_SVH

`ifndef SYNTH

// Checks that a condition holds at every clock edge outside reset.
`define UBDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define UBDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UBDE_ASSERT(lbl, prop, msg)
`define UBDE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/ubde_pkg.sv
// Shared types, constants and lookup tables of the baud divisor encoder.
// No dependencies; used by the top level and by the front and back parts.
package ubde_pkg;

    localparam int BAUD_W   = 26;   // request after the bitbang scaling
    localparam int DIV_NW   = 28;   // dividend width of all divider pipelines
    localparam int DIV2_DW  = 17;   // divisor width of the second dividers
    localparam int ACT_W    = 24;
    localparam int ENC_W    = 18;

    localparam logic [1:0] CLS_OLD  = 2'd0;
    localparam logic [1:0] CLS_BASE = 2'd1;
    localparam logic [1:0] CLS_HS   = 2'd2;

    localparam logic [1:0] REG_CHIP_CLASS = 2'd0;
    localparam logic [1:0] REG_BITBANG    = 2'd1;
    localparam logic [1:0] REG_PORT_INDEX = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_RATE = 2'd1;
    localparam logic [1:0] STATUS_OFF_TOL  = 2'd2;

    localparam int HS_CLK   = 120000000;
    localparam int BASE_CLK = 48000000;
    localparam int OLD_CLK  = 24000000;
    localparam int HS_DIV   = 10;
    localparam int BASE_DIV = 16;
    localparam int HS_LIMIT_X10 = HS_CLK / 'h3fff;
    localparam int HS_K     = HS_CLK * 16 / HS_DIV;
    localparam int BASE_K   = BASE_CLK * 16 / BASE_DIV;

    localparam int HS_THR0   = HS_CLK / HS_DIV;
    localparam int HS_THR1   = HS_CLK / (HS_DIV + HS_DIV / 2);
    localparam int HS_THR2   = HS_CLK / (2 * HS_DIV);
    localparam int BASE_THR0 = BASE_CLK / BASE_DIV;
    localparam int BASE_THR1 = BASE_CLK / (BASE_DIV + BASE_DIV / 2);
    localparam int BASE_THR2 = BASE_CLK / (2 * BASE_DIV);

    localparam int FRAC_DIV_LIMIT = 'h20000;
    localparam int FRAC_DIV_CLAMP = 'h1ffff;
    localparam int OLD_MIN_DIV    = 8;
    localparam int OLD_SMALL_DIV  = 16;
    localparam int OLD_MAX_DIV    = 'h1FFF8;
    localparam int OLD_ENC_ONE    = 'h4001;

    localparam logic [1:0] ENC_DIRECT0 = 2'd0;
    localparam logic [1:0] ENC_DIRECT1 = 2'd1;
    localparam logic [1:0] ENC_DIRECT2 = 2'd2;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_DIRECT,
        KIND_FRAC,
        KIND_OLD
    } kind_t;

    typedef struct packed {
        logic [1:0] chip_class;
        logic       bitbang_enable;
        logic [7:0] port_index;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BAUD_W-1:0] baud;
        logic              hs;
        logic              cls2;
        logic [1:0]        denc;
        logic [ACT_W-1:0]  dact;
    } item_t;

    typedef struct packed {
        item_t              item;
        logic [DIV2_DW-1:0] den_a;
        logic [DIV2_DW-1:0] den_b;
        logic [DIV_NW-1:0]  num_a;
        logic [DIV_NW-1:0]  num_b;
    } mid_t;

    typedef struct packed {
        item_t              item;
        logic [DIV2_DW-1:0] den_a;
    } back_side_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      value_word;
        logic [15:0]      index_word;
        logic [ACT_W-1:0] achieved_baud;
    } res_t;

    function automatic logic [2:0] frac_map(input logic [2:0] code);
        logic [2:0] r;
        unique case (code)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd1;
            3'd5:    r = 3'd5;
            3'd6:    r = 3'd6;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] old_up(input logic [2:0] code);
        logic [2:0] r;
        unique case (code)
            3'd3:    r = 3'd1;
            3'd5:    r = 3'd3;
            3'd6:    r = 3'd2;
            3'd7:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] old_dn(input logic [2:0] code);
        logic [2:0] r;
        unique case (code)
            3'd3:    r = 3'd1;
            3'd5:    r = 3'd1;
            3'd6:    r = 3'd2;
            3'd7:    r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Divisor in eighths to the chip's 14-bit integer plus 3-bit fraction code.
    function automatic logic [16:0] enc_div(input logic [DIV2_DW-1:0] t);
        return {frac_map(t[2:0]), t[16:3]};
    endfunction

endpackage

// File: src/uart_baud_divisor_encoder.sv
// Top level of the UART baud divisor encoder.
// Depends on ubde_pkg, ubde_fifo, ubde_front and ubde_back.

// Each request beat is a baud rate; each result beat carries a status, the
// value and index words of the encoded clock divisor and the rate that divisor
// really produces. Old-style chips search two adjusted candidates at 24 MHz,
// base chips use 48 MHz over 16 with a 3-bit fraction, and high-speed chips use
// 120 MHz over 10 (divisor bit 17 set, port number in the index low byte) when
// the request is high enough. With bitbang mode on, the request is scaled by
// four first. A zero request returns status 1 and zero fields; a rate more than
// 5 percent off, or under half the request, returns status 2 with the computed
// words. The block takes one request per clock and returns one result per
// clock while nothing stalls. The input register loads at the edge that
// accepts a request, then come a 28-stage divider pipeline for the base
// divisor, the middle queue, two parallel 28-stage divider pipelines that give
// the achieved rate, two encode and check stages, and the output queue.
// The middle queue lets the front keep taking requests while the back waits on
// a full output queue. Configuration registers are written with cfg_wr_en,
// cfg_addr and cfg_data and may change only when no request is in flight.
module uart_baud_divisor_encoder #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [23:0] requested_baud,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [15:0] value_word,
    output logic [15:0] index_word,
    output logic [23:0] achieved_baud
);
    import ubde_pkg::*;

    cfg_t cfg_reg;
    logic mid_push;
    mid_t mid_wdata;
    mid_t mid_rdata;
    logic mid_pop;
    logic mid_empty;
    logic mid_full;
    logic out_push;
    res_t out_wdata;
    res_t out_rdata;
    logic out_full;

    // Configuration registers; a write to an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chip_class     <= CLS_BASE;
            cfg_reg.bitbang_enable <= 1'b0;
            cfg_reg.port_index     <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_CHIP_CLASS: cfg_reg.chip_class     <= cfg_data[1:0];
                REG_BITBANG:    cfg_reg.bitbang_enable <= cfg_data[0];
                REG_PORT_INDEX: cfg_reg.port_index     <= cfg_data;
                default:        ;
            endcase
        end
    end

    ubde_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .push           (push),
        .full           (full),
        .requested_baud (requested_baud),
        .mid_push       (mid_push),
        .mid_data       (mid_wdata),
        .mid_full       (mid_full)
    );

    ubde_fifo #(
        .W     ($bits(mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .full  (mid_full)
    );

    ubde_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .port_index (cfg_reg.port_index),
        .mid_empty  (mid_empty),
        .mid_data   (mid_rdata),
        .mid_pop    (mid_pop),
        .out_push   (out_push),
        .out_data   (out_wdata),
        .out_full   (out_full)
    );

    ubde_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .pop   (pop && !empty),
        .rdata (out_rdata),
        .empty (empty),
        .full  (out_full)
    );

    assign status        = out_rdata.status;
    assign value_word    = out_rdata.value_word;
    assign index_word    = out_rdata.index_word;
    assign achieved_baud = out_rdata.achieved_baud;

endmodule

// File: src/ubde_fifo.sv
// Small register queue used between the front and back parts and at the output.
// Depends on uart_baud_divisor_encoder_macros.svh for its checks.
`include "uart_baud_divisor_encoder_macros.svh"

module ubde_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty,
    output logic         full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(DEPTH));
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `UBDE_ASSERT(a_no_overflow, !(push && full), "beat pushed into a full queue")
    `UBDE_ASSERT(a_no_underflow, !(pop && empty), "beat popped from an empty queue")
    `UBDE_ASSERT_NEXT(a_push_fills, (push && !pop), (cnt_reg != '0), "queue empty after a push")

endmodule

// File: src/ubde_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// No package dependency.
module ubde_div #(
    parameter int NW = 28,
    parameter int DW = 26,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          v_reg    [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] q_reg    [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic          v_p;
        logic [DW-1:0] rem_p;
        logic [NW-1:0] num_p;
        logic [NW-1:0] q_p;
        logic [DW-1:0] den_p;
        logic [SW-1:0] side_p;
        logic [DW:0]   trial;
        logic [DW:0]   sub;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign v_p    = in_valid;
            assign rem_p  = '0;
            assign num_p  = num;
            assign q_p    = '0;
            assign den_p  = den;
            assign side_p = side;
        end
        else
        begin : g_rest
            assign v_p    = v_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign num_p  = num_reg[k-1];
            assign q_p    = q_reg[k-1];
            assign den_p  = den_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        // Shift in the next dividend bit and subtract when the divisor fits.
        assign trial    = {rem_p, num_p[NW-1]};
        assign sub      = trial - {1'b0, den_p};
        assign ge       = (trial >= {1'b0, den_p});
        assign rem_next = ge ? sub[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_p << 1;
                q_reg[k]    <= {q_p[NW-2:0], ge};
                den_reg[k]  <= den_p;
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = q_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// File: src/ubde_front.sv
// Front part: takes requests, classifies them and finds the base divisor.
// Depends on ubde_pkg and ubde_div.
module ubde_front (
    input  logic           clk,
    input  logic           rst_n,
    input  ubde_pkg::cfg_t cfg,
    input  logic           push,
    output logic           full,
    input  logic [23:0]    requested_baud,
    output logic           mid_push,
    output ubde_pkg::mid_t mid_data,
    input  logic           mid_full
);
    import ubde_pkg::*;

    localparam int SW_ITEM = $bits(item_t);

    logic              en;
    logic              s0_v_reg;
    logic [BAUD_W-1:0] s0_baud_reg;
    item_t             item_in;
    item_t             div_item;
    logic [DIV_NW-1:0] num_in;
    logic [BAUD_W-1:0] den_in;
    logic              div_v;
    logic [DIV_NW-1:0] div_q;
    logic [SW_ITEM-1:0] div_side;
    logic [DIV_NW-1:0] bd_full;
    logic [DIV2_DW-1:0] bd;
    logic [DIV_NW-1:0] base;
    logic [DIV2_DW-1:0] t0;
    logic [DIV2_DW-1:0] t1;

    // Candidate divisor of old-style chips for one of the two trial steps.
    function automatic logic [DIV2_DW-1:0] old_cand(input logic [DIV_NW-1:0] b0,
                                                    input logic step);
        logic [DIV_NW-1:0] t;
        logic [DIV_NW-1:0] tu;
        t  = b0 + DIV_NW'(step);
        tu = t + DIV_NW'(old_up(t[2:0]));
        if (t <= DIV_NW'(OLD_MIN_DIV))
        begin
            return DIV2_DW'(OLD_MIN_DIV);
        end
        else if (b0 < DIV_NW'(OLD_SMALL_DIV))
        begin
            return DIV2_DW'(OLD_SMALL_DIV);
        end
        else if (tu > DIV_NW'(OLD_MAX_DIV))
        begin
            return DIV2_DW'(OLD_MAX_DIV);
        end
        return tu[DIV2_DW-1:0];
    endfunction

    assign en       = !(div_v && mid_full);
    assign full     = !en;
    assign mid_push = div_v && !mid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && push)
        begin
            s0_baud_reg <= cfg.bitbang_enable ? {requested_baud, 2'b00}
                                              : {2'b00, requested_baud};
        end
    end

    // Classification: direct codes need no quotient; every item still passes the divider.
    always_comb
    begin
        logic hs;
        logic [29:0] b10;
        b10 = 30'(s0_baud_reg) * 30'd10;
        hs  = (cfg.chip_class == CLS_HS) && (b10 > 30'(HS_LIMIT_X10));
        item_in.baud = s0_baud_reg;
        item_in.hs   = hs;
        item_in.cls2 = (cfg.chip_class == CLS_HS);
        item_in.denc = ENC_DIRECT0;
        item_in.dact = '0;
        num_in       = hs ? DIV_NW'(HS_K) : DIV_NW'(BASE_K);
        den_in       = (s0_baud_reg == '0) ? BAUD_W'(1) : s0_baud_reg;
        if (s0_baud_reg == '0)
        begin
            item_in.kind = KIND_ZERO;
        end
        else if (cfg.chip_class == CLS_OLD)
        begin
            item_in.kind = KIND_OLD;
            num_in       = DIV_NW'(OLD_CLK);
        end
        else if (s0_baud_reg >= (hs ? BAUD_W'(HS_THR0) : BAUD_W'(BASE_THR0)))
        begin
            item_in.kind = KIND_DIRECT;
            item_in.denc = ENC_DIRECT0;
            item_in.dact = hs ? ACT_W'(HS_THR0) : ACT_W'(BASE_THR0);
        end
        else if (s0_baud_reg >= (hs ? BAUD_W'(HS_THR1) : BAUD_W'(BASE_THR1)))
        begin
            item_in.kind = KIND_DIRECT;
            item_in.denc = ENC_DIRECT1;
            item_in.dact = hs ? ACT_W'(HS_THR1) : ACT_W'(BASE_THR1);
        end
        else if (s0_baud_reg >= (hs ? BAUD_W'(HS_THR2) : BAUD_W'(BASE_THR2)))
        begin
            item_in.kind = KIND_DIRECT;
            item_in.denc = ENC_DIRECT2;
            item_in.dact = hs ? ACT_W'(HS_THR2) : ACT_W'(BASE_THR2);
        end
        else
        begin
            item_in.kind = KIND_FRAC;
        end
    end

    ubde_div #(
        .NW (DIV_NW),
        .DW (BAUD_W),
        .SW (SW_ITEM)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_v_reg),
        .num       (num_in),
        .den       (den_in),
        .side      (item_in),
        .out_valid (div_v),
        .quo       (div_q),
        .side_out  (div_side)
    );

    assign div_item = item_t'(div_side);

    // Rounded fractional divisor, and the two old-chip candidates.
    assign bd_full = DIV_NW'(({1'b0, div_q} + 1'b1) >> 1);
    assign bd      = (bd_full > DIV_NW'(FRAC_DIV_LIMIT)) ? DIV2_DW'(FRAC_DIV_CLAMP) :
                     (bd_full == '0) ? DIV2_DW'(1) : bd_full[DIV2_DW-1:0];
    assign base    = div_q - DIV_NW'(old_dn(div_q[2:0]));
    assign t0      = old_cand(base, 1'b0);
    assign t1      = old_cand(base, 1'b1);

    always_comb
    begin
        mid_data.item  = div_item;
        mid_data.den_b = t1;
        mid_data.num_b = DIV_NW'(OLD_CLK) + DIV_NW'(t1 >> 1);
        if (div_item.kind == KIND_OLD)
        begin
            mid_data.den_a = t0;
            mid_data.num_a = DIV_NW'(OLD_CLK) + DIV_NW'(t0 >> 1);
        end
        else
        begin
            mid_data.den_a = bd;
            mid_data.num_a = div_item.hs ? DIV_NW'(HS_K) : DIV_NW'(BASE_K);
        end
    end

endmodule

// File: src/ubde_back.sv
// Back part: divides for the achieved rate, encodes the divisor, checks tolerance.
// Depends on ubde_pkg and ubde_div.
module ubde_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     port_index,
    input  logic           mid_empty,
    input  ubde_pkg::mid_t mid_data,
    output logic           mid_pop,
    output logic           out_push,
    output ubde_pkg::res_t out_data,
    input  logic           out_full
);
    import ubde_pkg::*;

    localparam int SW_A = $bits(back_side_t);

    logic               en;
    back_side_t         side_in;
    logic [SW_A-1:0]    side_a;
    back_side_t         side_q;
    logic               va;
    logic               vb;
    logic [DIV_NW-1:0]  qa;
    logic [DIV_NW-1:0]  qb;
    logic [DIV2_DW-1:0] den_b_q;

    logic               e1_v_reg;
    logic               e1_zero_reg, e1_zero_next;
    logic [ACT_W-1:0]   e1_act_reg, e1_act_next;
    logic [ENC_W-1:0]   e1_enc_reg, e1_enc_next;
    logic               e1_cls2_reg;
    logic [BAUD_W-1:0]  e1_baud_reg;

    logic               e2_v_reg;
    res_t               e2_res_reg, e2_res_next;

    assign en       = !(e2_v_reg && out_full);
    assign mid_pop  = en && !mid_empty;
    assign out_push = e2_v_reg && !out_full;
    assign out_data = e2_res_reg;

    assign side_in.item  = mid_data.item;
    assign side_in.den_a = mid_data.den_a;

    ubde_div #(
        .NW (DIV_NW),
        .DW (DIV2_DW),
        .SW (SW_A)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_pop),
        .num       (mid_data.num_a),
        .den       (mid_data.den_a),
        .side      (side_in),
        .out_valid (va),
        .quo       (qa),
        .side_out  (side_a)
    );

    ubde_div #(
        .NW (DIV_NW),
        .DW (DIV2_DW),
        .SW (DIV2_DW)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_pop),
        .num       (mid_data.num_b),
        .den       (mid_data.den_b),
        .side      (mid_data.den_b),
        .out_valid (vb),
        .quo       (qb),
        .side_out  (den_b_q)
    );

    assign side_q = back_side_t'(side_a);

    // Encode stage: pick the candidate and form the divisor word.
    always_comb
    begin
        logic [DIV_NW-1:0]  diff0;
        logic [DIV_NW-1:0]  diff1;
        logic [DIV_NW-1:0]  b_ext;
        logic               sel1;
        logic [DIV2_DW-1:0] t;
        logic [16:0]        e;
        b_ext = DIV_NW'(side_q.item.baud);
        diff0 = (qa < b_ext) ? b_ext - qa : qa - b_ext;
        diff1 = (qb < b_ext) ? b_ext - qb : qb - b_ext;
        sel1  = (diff1 < diff0);
        t     = sel1 ? den_b_q : side_q.den_a;
        e     = enc_div(t);
        e1_zero_next = 1'b0;
        e1_act_next  = '0;
        e1_enc_next  = '0;
        unique case (side_q.item.kind)
            KIND_ZERO:
            begin
                e1_zero_next = 1'b1;
            end
            KIND_DIRECT:
            begin
                e1_act_next = side_q.item.dact;
                e1_enc_next = {side_q.item.hs, 15'd0, side_q.item.denc};
            end
            KIND_FRAC:
            begin
                e1_act_next = ACT_W'(({1'b0, qa} + 1'b1) >> 1);
                e1_enc_next = {side_q.item.hs, enc_div(side_q.den_a)};
            end
            default:
            begin
                // Old-style chips remap two codes of the 17-bit divisor.
                e1_act_next = sel1 ? ACT_W'(qb) : ACT_W'(qa);
                if (e == 17'd1)
                begin
                    e = 17'd0;
                end
                else if (e == 17'(OLD_ENC_ONE))
                begin
                    e = 17'd1;
                end
                e1_enc_next = {1'b0, e};
            end
        endcase
    end

    // Output stage: tolerance check and word layout.
    always_comb
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic        bad;
        a   = 32'(e1_act_reg);
        b   = 32'(e1_baud_reg);
        bad = ((a << 1) < b) ||
              ((a < b) ? (a * 32'd21 < b * 32'd20) : (b * 32'd21 < a * 32'd20));
        e2_res_next.status        = bad ? STATUS_OFF_TOL : STATUS_OK;
        e2_res_next.value_word    = e1_enc_reg[15:0];
        e2_res_next.index_word    = e1_cls2_reg ? {6'd0, e1_enc_reg[17:16], port_index}
                                                : {14'd0, e1_enc_reg[17:16]};
        e2_res_next.achieved_baud = e1_act_reg;
        if (e1_zero_reg)
        begin
            e2_res_next = '0;
            e2_res_next.status = STATUS_BAD_RATE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg <= va && vb;
            e2_v_reg <= e1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_zero_reg <= e1_zero_next;
            e1_act_reg  <= e1_act_next;
            e1_enc_reg  <= e1_enc_next;
            e1_cls2_reg <= side_q.item.cls2;
            e1_baud_reg <= side_q.item.baud;
            e2_res_reg  <= e2_res_next;
        end
    end

endmodule

// File: tb/uart_baud_divisor_encoder_tb.sv
// Self-checking testbench for the UART baud divisor encoder.
// Depends on ubde_pkg and uart_baud_divisor_encoder; it predicts each result
// beat from the request and the register settings, and compares every field.
module uart_baud_divisor_encoder_tb;
    import ubde_pkg::*;

    // One predicted result beat, in the block's own field widths.
    typedef struct {
        logic [1:0]  status;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [23:0] achieved_baud;
        logic [23:0] request;
    } divisor_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_data;
    logic        push;
    logic        full;
    logic [23:0] requested_baud;
    logic        empty;
    logic        pop;
    logic [1:0]  status;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [23:0] achieved_baud;

    // Our own copy of the register file, updated as each register is written.
    logic [1:0] shadow_class;
    logic       shadow_bitbang;
    logic [7:0] shadow_port;

    divisor_result_t pending_results[$];

    int error_count;
    int requests_sent;
    int results_checked;
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold_cycles;

    // Idle wait after the last result, longer than the path through both divider stages.
    localparam int SETTLE_CYCLES = 80;

    uart_baud_divisor_encoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .requested_baud (requested_baud),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .value_word     (value_word),
        .index_word     (index_word),
        .achieved_baud  (achieved_baud)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Fraction code of the chip for the low three bits of a divisor in eighths.
    function automatic longint unsigned eighths_to_code(input longint unsigned low3);
        case (low3 & 7)
            1:       return 3;
            2:       return 2;
            3:       return 4;
            4:       return 1;
            5:       return 5;
            6:       return 6;
            7:       return 7;
            default: return 0;
        endcase
    endfunction

    // Adjustment added to an old-chip candidate divisor.
    function automatic longint unsigned old_round_up(input longint unsigned low3);
        case (low3 & 7)
            3:       return 1;
            5:       return 3;
            6:       return 2;
            7:       return 1;
            default: return 0;
        endcase
    endfunction

    // Adjustment taken off the old-chip base divisor.
    function automatic longint unsigned old_round_down(input longint unsigned low3);
        case (low3 & 7)
            3:       return 1;
            5:       return 1;
            6:       return 2;
            7:       return 3;
            default: return 0;
        endcase
    endfunction

    // Fractional divisor on a given clock and prescaler; returns the achieved rate.
    function automatic longint unsigned frac_divisor(input longint unsigned clk_hz,
                                                     input longint unsigned prescale,
                                                     input longint unsigned baud,
                                                     output longint unsigned enc);
        longint unsigned eighths;
        longint unsigned div;
        longint unsigned rate;
        if (baud >= clk_hz / prescale)
        begin
            enc = 0;
            return clk_hz / prescale;
        end
        if (baud >= clk_hz / (prescale + prescale / 2))
        begin
            enc = 1;
            return clk_hz / (prescale + prescale / 2);
        end
        if (baud >= clk_hz / (2 * prescale))
        begin
            enc = 2;
            return clk_hz / (2 * prescale);
        end
        eighths = clk_hz * 16 / prescale / baud;
        div = eighths[0] ? eighths / 2 + 1 : eighths / 2;
        if (div > 64'h20000)
            div = 64'h1ffff;
        if (div == 0)
            div = 1;
        rate = clk_hz * 16 / prescale / div;
        rate = rate[0] ? rate / 2 + 1 : rate / 2;
        enc = (div >> 3) | (eighths_to_code(div) << 14);
        return rate;
    endfunction

    // Old-style chip: two adjusted candidates around the 24 MHz base divisor.
    // Note that the small-divisor test looks at the base, not the candidate.
    function automatic longint unsigned old_chip_divisor(input longint unsigned baud,
                                                         output longint unsigned enc);
        longint unsigned base;
        longint unsigned cand;
        longint unsigned rate;
        longint unsigned diff;
        longint unsigned best_div;
        longint unsigned best_rate;
        longint unsigned best_diff;
        best_div = 0;
        best_rate = 0;
        best_diff = 0;
        base = 24000000 / baud;
        base = base - old_round_down(base);
        for (int i = 0; i < 2; i++)
        begin
            cand = base + i;
            if (cand <= 8)
                cand = 8;
            else if (base < 16)
                cand = 16;
            else
            begin
                cand = cand + old_round_up(cand);
                if (cand > 64'h1fff8)
                    cand = 64'h1fff8;
            end
            rate = (24000000 + cand / 2) / cand;
            diff = (rate < baud) ? baud - rate : rate - baud;
            if (i == 0 || diff < best_diff)
            begin
                best_div = cand;
                best_rate = rate;
                best_diff = diff;
                if (diff == 0)
                    break;
            end
        end
        enc = (best_div >> 3) | (eighths_to_code(best_div) << 14);
        // Two codes have a special meaning on these chips and are remapped.
        if (enc == 1)
            enc = 0;
        else if (enc == 64'h4001)
            enc = 1;
        return best_rate;
    endfunction

    // Full prediction of one result beat under the current register copy.
    function automatic divisor_result_t predict_divisor(input logic [23:0] request);
        divisor_result_t r;
        longint unsigned baud;
        longint unsigned enc;
        longint unsigned rate;
        longint unsigned index;
        logic off;
        r.request = request;
        baud = 64'(request);
        if (shadow_bitbang)
            baud = baud * 4;
        if (baud == 0)
        begin
            r.status = STATUS_BAD_RATE;
            r.value_word = '0;
            r.index_word = '0;
            r.achieved_baud = '0;
            return r;
        end
        if (shadow_class == CLS_HS)
        begin
            if (baud * 10 > 120000000 / 64'h3fff)
            begin
                rate = frac_divisor(120000000, 10, baud, enc);
                enc = enc | 64'h20000;
            end
            else
                rate = frac_divisor(48000000, 16, baud, enc);
            index = ((enc >> 8) & 64'hff00) | 64'(shadow_port);
        end
        else
        begin
            if (shadow_class == CLS_OLD)
                rate = old_chip_divisor(baud, enc);
            else
                rate = frac_divisor(48000000, 16, baud, enc);
            index = (enc >> 16) & 64'hffff;
        end
        off = (rate * 2 < baud) ||
              ((rate < baud) ? (rate * 21 < baud * 20) : (baud * 21 < rate * 20));
        r.status = off ? STATUS_OFF_TOL : STATUS_OK;
        r.value_word = enc[15:0];
        r.index_word = index[15:0];
        r.achieved_baud = rate[23:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want, input logic [23:0] request);
        error_count++;
        $display("mismatch in %s for request %0d: got %0d, expected %0d",
                 what, request, got, want);
    endtask

    // Result side: pops at random, holds off when asked, checks every beat.
    always @(posedge clk)
    begin
        divisor_result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("result beat arrived with no request outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status),
                                        want.request);
                    if (value_word !== want.value_word)
                        report_mismatch("value_word", 64'(value_word),
                                        64'(want.value_word), want.request);
                    if (index_word !== want.index_word)
                        report_mismatch("index_word", 64'(index_word),
                                        64'(want.index_word), want.request);
                    if (achieved_baud !== want.achieved_baud)
                        report_mismatch("achieved_baud", 64'(achieved_baud),
                                        64'(want.achieved_baud), want.request);
                end
            end
            if (recv_hold_cycles > 0)
            begin
                recv_hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Write one register while the block is idle and keep our copy in step.
    // The write enable is left high; the caller drops it after its last write.
    task automatic write_register(input logic [1:0] addr, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        if (addr == REG_CHIP_CLASS)
            shadow_class = data[1:0];
        else if (addr == REG_BITBANG)
            shadow_bitbang = data[0];
        else if (addr == REG_PORT_INDEX)
            shadow_port = data;
    endtask

    task automatic apply_settings(input logic [1:0] chip, input logic bitbang,
                                  input logic [7:0] port);
        write_register(REG_CHIP_CLASS, {6'd0, chip});
        write_register(REG_BITBANG, {7'd0, bitbang});
        write_register(REG_PORT_INDEX, port);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one request beat, possibly after an idle gap, and wait for acceptance.
    // Push stays high afterward so back-to-back beats follow without a gap.
    task automatic send_request(input logic [23:0] baud);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        push <= 1'b1;
        requested_baud <= baud;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(predict_divisor(baud));
        requests_sent++;
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Requests spread over the ranges that matter: common rates, rates near
    // the divisor thresholds, very low rates that clamp, and the whole field.
    function automatic logic [23:0] pick_request();
        case ($urandom_range(0, 11))
            0:       return 24'($urandom_range(0, 3));
            1:       return 24'($urandom_range(1, 400));
            2:       return 24'($urandom_range(400, 20000));
            3:       return 24'($urandom_range(700, 760));
            4:       return 24'($urandom_range(20000, 1000000));
            5:       return 24'($urandom_range(1000000, 3200000));
            6:       return 24'($urandom_range(5500000, 12500000));
            7:       return 24'($urandom_range(0, 24'hffffff));
            8:       return 24'(24'hffffff - $urandom_range(0, 1000));
            9:
            begin
                case ($urandom_range(0, 5))
                    0:       return 24'd9600;
                    1:       return 24'd115200;
                    2:       return 24'd921600;
                    3:       return 24'd3000000;
                    4:       return 24'd2000000;
                    default: return 24'd12000000;
                endcase
            end
            default: return 24'($urandom_range(1, 4000000));
        endcase
    endfunction

    // Directed part: extremes and the thresholds of each chip class.
    task automatic test_directed();
        logic [23:0] old_list[$];
        logic [23:0] base_list[$];
        logic [23:0] hs_list[$];
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Old chips: divisor floor at 8, the small-base quirk, the top clamp,
        // and the rate that hits the remapped divisor code.
        old_list = '{24'd0, 24'd3000000, 24'd2000000, 24'd1500000, 24'd183,
                     24'd1, 24'd24000000, 24'd16777215};
        base_list = '{24'd3000000, 24'd2000000, 24'd1500000, 24'd100, 24'd1,
                      24'd9600};
        hs_list = '{24'd12000000, 24'd8000000, 24'd6000000, 24'd733, 24'd732,
                    24'd16777215, 24'd115200, 24'd0};
        apply_settings(CLS_OLD, 1'b0, 8'd1);
        foreach (old_list[i])
            send_request(old_list[i]);
        drain_results();
        apply_settings(CLS_BASE, 1'b0, 8'd0);
        foreach (base_list[i])
            send_request(base_list[i]);
        drain_results();
        apply_settings(CLS_HS, 1'b0, 8'd255);
        foreach (hs_list[i])
            send_request(hs_list[i]);
        drain_results();
        // Selector value three behaves as a base chip; bitbang scales past 24 bits.
        apply_settings(2'd3, 1'b1, 8'd0);
        send_request(24'd16777215);
        send_request(24'd750000);
        send_request(24'd0);
        drain_results();
    endtask

    // One random phase under one register setting and one idling pattern.
    task automatic test_random_phase(input int count, input int idle_pct,
                                     input int stall_pct, input logic [1:0] chip,
                                     input logic bitbang, input logic [7:0] port);
        apply_settings(chip, bitbang, port);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_request(pick_request());
        drain_results();
    endtask

    // The receiver holds off long enough that both queues fill and full rises
    // while the sender keeps offering beats.
    task automatic test_backpressure();
        apply_settings(CLS_HS, 1'b0, 8'd42);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold_cycles = 300;
        repeat (80) send_request(pick_request());
        drain_results();
    endtask

    task automatic test_random();
        int idle_modes[4];
        int stall_modes[4];
        idle_modes = '{0, 45, 0, 37};
        stall_modes = '{0, 0, 45, 37};
        for (int phase = 0; phase < 8; phase++)
            test_random_phase(150, idle_modes[phase % 4], stall_modes[phase % 4],
                              phase[1:0], phase[2],
                              (phase == 2) ? 8'd255 : (phase == 6) ? 8'd0
                                           : 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        requested_baud = '0;
        error_count = 0;
        requests_sent = 0;
        results_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold_cycles = 0;
        // Register values after reset.
        shadow_class = CLS_BASE;
        shadow_bitbang = 1'b0;
        shadow_port = 8'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // A few beats under the reset settings before any register is written.
        repeat (10) send_request(pick_request());
        drain_results();
        test_directed();
        test_backpressure();
        test_random();
        $display("Checked %0d result beats from %0d requests over all chip classes,",
                 results_checked, requests_sent);
        $display("bitbang on and off, port extremes, idle gaps and a long stall.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("timeout with %0d results still outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
